>>> sv/tb2i8_pkg.sv
// Shared types and constants for the tensor byte to int8 converter.
`default_nettype none

package tb2i8_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = 32;
	localparam int INDEX_W         = 32;
	localparam int PHASE_W         = 6;
	localparam int GATHER_W        = 24;
	localparam int MAG_W           = 25;
	localparam int SHIFT_W         = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_TENSOR_TYPE  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_COUNT = 1'd1;

	// Element / block lengths in bytes
	localparam logic [PHASE_W-1:0] LEN_F32         = 6'd4;
	localparam logic [PHASE_W-1:0] LEN_F16         = 6'd2;
	localparam logic [PHASE_W-1:0] LEN_Q8_0        = 6'd34;
	localparam logic [PHASE_W-1:0] LEN_RAW         = 6'd1;
	localparam logic [PHASE_W-1:0] Q8_SCALE_BYTES  = 6'd2;
	localparam logic [PHASE_W-1:0] F32_LAST_PHASE  = 6'd3;
	localparam logic [PHASE_W-1:0] F16_LAST_PHASE  = 6'd1;

	localparam logic [4:0] F16_EXP_MAX   = 5'h1F;
	localparam logic [4:0] F16_EXP_SAT   = 5'd25;
	localparam logic [7:0] F32_EXP_MAX   = 8'hFF;
	localparam logic [9:0] F32_BIAS_OFS  = 10'd150;
	localparam logic [9:0] F32_SHIFT_LIM = 10'd63;

	typedef enum logic [1:0] {
		TT_F32  = 2'd0,
		TT_F16  = 2'd1,
		TT_Q8_0 = 2'd2,
		TT_RAW  = 2'd3
	} tensor_type_t;

	// How the final stage forms the weight
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_SAT  = 2'd1,
		CLS_NUM  = 2'd2,
		CLS_RAW  = 2'd3
	} cls_t;

endpackage

`default_nettype wire

>>> sv/tb2i8_ifs.sv
// Channel interfaces: tensor byte input, weight output, register write.
`default_nettype none

interface tb2i8_byte_if
	import tb2i8_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tb2i8_weight_if
	import tb2i8_pkg::*;
();
	logic               valid;
	logic               ready;
	logic signed [7:0]  weight;
	logic [INDEX_W-1:0] weight_index;
	logic               last_weight;

	modport source (output valid, output weight, output weight_index, output last_weight,
		input ready);
	modport sink   (input valid, input weight, input weight_index, input last_weight,
		output ready);
endinterface

interface tb2i8_cfg_if
	import tb2i8_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tensor_bytes_to_int8.sv
// Tensor byte stream to saturated int8 weight converter, top level.
//
// Usage: raw little-endian tensor bytes enter on the bytes channel, one byte
// per beat, with first_byte set on a tensor's first byte. Each complete element
// leaves on the weights channel as a signed 8-bit weight with its index and a
// last flag. Register 0 (tensor_type) selects single float, half float, Q8_0
// blocks or raw copy; register 1 (weight_count) sets how many weights a tensor
// holds. Registers are written through cfg, which is always ready; the user must
// write them only while the block is idle, as the block does not enforce this.
// On its way to weights a result passes through stage 1 (gather/state update),
// stage 2 (float decode and rounding) and the output register (shift and
// saturate). Throughput: one byte per cycle while weights is not stalled, set
// by the per-byte counter update in the accept stage.
// Beats that produce no weight (Q8_0 scale bytes, partial floats, bytes after
// the last weight) update state only.
// Reset clears the pipeline and leaves the block waiting for a first_byte;
// tensor_type resets to Q8_0 and weight_count to zero.
// When the receiver stalls, results hold in the output register and the two
// stages behind it fill; bytes is then held off until space frees up.
`default_nettype none

module tensor_bytes_to_int8
	import tb2i8_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	tb2i8_cfg_if.sink        cfg,
	tb2i8_byte_if.sink       bytes,
	tb2i8_weight_if.source   weights
);

	localparam int CMP_W = (COUNT_WIDTH > INDEX_W) ? COUNT_WIDTH : INDEX_W;

	// Configuration
	tensor_type_t         tensor_type_q;
	logic [INDEX_W-1:0]   weight_count_q;

	// Stream state
	logic [GATHER_W-1:0]    gather_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [COUNT_WIDTH-1:0] done_q;
	logic                   finished_q;

	logic [GATHER_W-1:0]    gather_n;
	logic [PHASE_W-1:0]     phase_n;
	logic [COUNT_WIDTH-1:0] done_n;
	logic                   finished_n;
	logic                   emit;
	logic [31:0]            word;
	logic [INDEX_W-1:0]     idx;
	logic                   last;

	// Stage 1: assembled element
	logic                 valid_s1;
	logic [31:0]          word_s1;
	tensor_type_t         type_s1;
	logic [INDEX_W-1:0]   idx_s1;
	logic                 last_s1;

	// Stage 2: magnitude before the final shift
	logic                 valid_s2;
	cls_t                 cls_s2;
	logic                 neg_s2;
	logic [MAG_W-1:0]     mag_s2;
	logic [SHIFT_W-1:0]   sh_s2;
	logic [INDEX_W-1:0]   idx_s2;
	logic                 last_s2;

	// Output register
	logic                 out_valid_q;
	logic signed [7:0]    weight_q;
	logic [INDEX_W-1:0]   index_q;
	logic                 last_q;

	logic out_en, s2_en, s1_en, accept;

	assign out_en      = !out_valid_q || weights.ready;
	assign s2_en       = !valid_s2 || out_en;
	assign s1_en       = !valid_s1 || s2_en;
	assign bytes.ready = s1_en;
	assign accept      = bytes.valid && s1_en;
	assign cfg.ready   = 1'b1;

	assign weights.valid        = out_valid_q;
	assign weights.weight       = weight_q;
	assign weights.weight_index = index_q;
	assign weights.last_weight  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tensor_type_q  <= TT_Q8_0;
			weight_count_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TENSOR_TYPE: begin
					tensor_type_q <= tensor_type_t'(cfg.data[1:0]);
				end
				REG_WEIGHT_COUNT: begin
					weight_count_q <= cfg.data[INDEX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Accept stage: counters, byte gathering, emit decision
	always_comb begin
		logic [GATHER_W-1:0]    gather_c;
		logic [PHASE_W-1:0]     phase_c;
		logic [COUNT_WIDTH-1:0] done_c;
		logic                   finished_c;
		logic [PHASE_W-1:0]     len;
		logic [PHASE_W-1:0]     ph;
		logic [PHASE_W-1:0]     ph_adv;
		logic [7:0]             b;

		b          = bytes.data_byte;
		gather_c   = bytes.first_byte ? '0 : gather_q;
		phase_c    = bytes.first_byte ? '0 : phase_q;
		done_c     = bytes.first_byte ? '0 : done_q;
		finished_c = bytes.first_byte ? 1'b0 : finished_q;

		gather_n   = gather_c;
		phase_n    = phase_c;
		done_n     = done_c;
		finished_n = finished_c;
		emit       = 1'b0;
		word       = '0;
		last       = 1'b0;
		ph         = '0;
		ph_adv     = '0;
		idx        = INDEX_W'(CMP_W'(done_c));

		case (tensor_type_q)
			TT_F32:  len = LEN_F32;
			TT_F16:  len = LEN_F16;
			TT_Q8_0: len = LEN_Q8_0;
			default: len = LEN_RAW;
		endcase

		if (!finished_c) begin
			if (CMP_W'(done_c) >= CMP_W'(weight_count_q)) begin
				finished_n = 1'b1;
			end else begin
				ph = (phase_c >= len) ? '0 : phase_c;
				case (tensor_type_q)
					TT_F32: begin
						if (ph == F32_LAST_PHASE) begin
							emit = 1'b1;
							word = {b, gather_c};
						end else begin
							case (ph[1:0])
								2'd0:    gather_n = gather_c | {16'b0, b};
								2'd1:    gather_n = gather_c | {8'b0, b, 8'b0};
								default: gather_n = gather_c | {b, 16'b0};
							endcase
						end
					end
					TT_F16: begin
						if (ph == F16_LAST_PHASE) begin
							emit = 1'b1;
							word = {16'b0, b, gather_c[7:0]};
						end else begin
							gather_n = {16'b0, b};
						end
					end
					TT_Q8_0: begin
						if (ph >= Q8_SCALE_BYTES) begin
							emit = 1'b1;
							word = {24'b0, b};
						end
					end
					default: begin
						emit = 1'b1;
						word = {24'b0, b};
					end
				endcase
				ph_adv = ph + PHASE_W'(1);
				if (ph_adv >= len) begin
					phase_n  = '0;
					gather_n = '0;
				end else begin
					phase_n = ph_adv;
				end
				if (emit) begin
					done_n = done_c + COUNT_WIDTH'(1);
					// Counter wrap also ends the tensor
					last = (done_n == '0) || (CMP_W'(done_n) == CMP_W'(weight_count_q));
					finished_n = last;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q   <= '0;
			phase_q    <= '0;
			done_q     <= '0;
			finished_q <= 1'b1;
		end else if (accept) begin
			gather_q   <= gather_n;
			phase_q    <= phase_n;
			done_q     <= done_n;
			finished_q <= finished_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && accept && emit) begin
			word_s1 <= word;
			type_s1 <= tensor_type_q;
			idx_s1  <= idx;
			last_s1 <= last;
		end
	end

	// Decode stage: exponent classes, significand times 127, float32 rounding
	cls_t               cls_c;
	logic               neg_c;
	logic [MAG_W-1:0]   mag_c;
	logic [SHIFT_W-1:0] sh_c;

	always_comb begin
		logic [4:0]  h_ex;
		logic [17:0] h_prod;
		logic [4:0]  h_sh;
		logic [7:0]  f_ex;
		logic [23:0] f_sig;
		logic [30:0] f_p;
		logic        f_d7;
		logic [23:0] f_r;
		logic        f_rnd;
		logic        f_stk;
		logic [9:0]  f_sh;

		cls_c = CLS_ZERO;
		neg_c = 1'b0;
		mag_c = '0;
		sh_c  = '0;

		h_ex   = word_s1[14:10];
		h_prod = {7'b0, 1'b1, word_s1[9:0]} * 18'd127;
		h_sh   = F16_EXP_SAT - h_ex;

		f_ex  = word_s1[30:23];
		f_sig = {1'b1, word_s1[22:0]};
		f_p   = {f_sig, 7'b0} - {7'b0, f_sig};
		f_d7  = f_p[30];
		f_r   = f_d7 ? f_p[30:7] : f_p[29:6];
		f_rnd = f_d7 ? f_p[6] : f_p[5];
		f_stk = f_d7 ? (|f_p[5:0]) : (|f_p[4:0]);
		// Right shift still needed after rounding: 150 - d - exponent
		f_sh  = F32_BIAS_OFS - {2'b0, f_ex} - (f_d7 ? 10'd7 : 10'd6);

		case (type_s1)
			TT_F16: begin
				neg_c = word_s1[15];
				if (h_ex == '0) begin
					cls_c = CLS_ZERO;
				end else if (h_ex == F16_EXP_MAX) begin
					cls_c = (word_s1[9:0] != '0) ? CLS_ZERO : CLS_SAT;
				end else if (h_ex >= F16_EXP_SAT) begin
					cls_c = CLS_SAT;
				end else begin
					cls_c = CLS_NUM;
					mag_c = MAG_W'(h_prod);
					sh_c  = SHIFT_W'(h_sh);
				end
			end
			TT_F32: begin
				neg_c = word_s1[31];
				if (f_ex == '0) begin
					cls_c = CLS_ZERO;
				end else if (f_ex == F32_EXP_MAX) begin
					cls_c = (word_s1[22:0] != '0) ? CLS_ZERO : CLS_SAT;
				end else if (f_sh[9] || f_sh == '0) begin
					cls_c = CLS_SAT;
				end else if (f_sh >= F32_SHIFT_LIM) begin
					cls_c = CLS_ZERO;
				end else begin
					cls_c = CLS_NUM;
					mag_c = {1'b0, f_r} + MAG_W'(f_rnd && (f_stk || f_r[0]));
					sh_c  = f_sh[SHIFT_W-1:0];
				end
			end
			default: begin
				cls_c = CLS_RAW;
				mag_c = MAG_W'(word_s1[7:0]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1) begin
			cls_s2  <= cls_c;
			neg_s2  <= neg_c;
			mag_s2  <= mag_c;
			sh_s2   <= sh_c;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
		end
	end

	// Final stage: truncating shift and signed saturation, or zero, saturated or raw value by class
	logic [7:0] weight_c;

	always_comb begin
		logic [MAG_W-1:0] v;

		v = mag_s2 >> sh_s2;
		case (cls_s2)
			CLS_ZERO: weight_c = 8'h00;
			CLS_SAT:  weight_c = neg_s2 ? 8'h80 : 8'h7F;
			CLS_RAW:  weight_c = mag_s2[7:0];
			default: begin
				if (neg_s2) begin
					weight_c = (v >= MAG_W'(128)) ? 8'h80 : (8'h00 - v[7:0]);
				end else begin
					weight_c = (v > MAG_W'(127)) ? 8'h7F : v[7:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			weight_q <= weight_c;
			index_q  <= idx_s2;
			last_q   <= last_s2;
		end
	end

endmodule

`default_nettype wire
